// File: src/base64_stream_decoder_defines.svh
// Assertion macros used by the checker file
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define B64SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/b64sd_pkg.sv
package b64sd_pkg;

  localparam int CHAR_W   = 8;
  localparam int SEXTET_W = 6;
  localparam int BYTE_W   = 8;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;
  localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

  // Position of the next character within its group of four
  typedef enum logic [3:0] {
    SLOT_0 = 4'b0001,
    SLOT_1 = 4'b0010,
    SLOT_2 = 4'b0100,
    SLOT_3 = 4'b1000
  } slot_t;

  typedef struct packed {
    logic [SEXTET_W-1:0] sextet;
    logic                bad;
  } sextet_t;

  // Alphabet lookup; NUL reads as 0 unflagged, anything else outside it reads as 63 and is flagged
  function automatic sextet_t char_to_sextet(input logic [CHAR_W-1:0] ch);
    sextet_t r;
    r.bad    = 1'b0;
    r.sextet = 6'd63;
    case (ch) inside
      [8'h41:8'h5A]: r.sextet = 6'(ch - 8'h41);
      [8'h61:8'h7A]: r.sextet = 6'(ch - 8'h47);
      [8'h30:8'h39]: r.sextet = 6'(ch + 8'h04);
      8'h2B:         r.sextet = 6'd62;
      8'h2F:         r.sextet = 6'd63;
      NUL_CHAR:      r.sextet = 6'd0;
      default:       r.bad    = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: src/b64sd_char_if.sv
interface b64sd_char_if;
  import b64sd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);

endinterface

// File: src/b64sd_byte_if.sv
interface b64sd_byte_if;
  import b64sd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              bad_symbol;
  logic              end_of_text;

  modport source (output valid, output data_byte, output bad_symbol, output end_of_text,
                  input ready);
  modport sink   (input valid, input data_byte, input bad_symbol, input end_of_text,
                  output ready);

endinterface

// File: src/base64_stream_decoder.sv
// A byte appears in the output register in the cycle after its character transfer.
// Throughput: one character per cycle; the single output register takes a new result
// in the same cycle its current one is taken, so input stalls only on output back-pressure.
// Reset (rst, synchronous, active high): group position back to the first slot, held
// sextet and skip flag cleared, output register emptied.
module base64_stream_decoder (
  input  logic            clk,
  input  logic            rst,
  b64sd_char_if.sink      char_in,
  b64sd_byte_if.source    byte_out
);
  import b64sd_pkg::*;

  slot_t               group_slot, group_slot_next;
  logic [SEXTET_W-1:0] held_sextet, held_sextet_next;
  logic                skip_rest, skip_rest_next;

  logic                out_valid;
  logic [BYTE_W-1:0]   data_byte;
  logic                bad_symbol;
  logic                end_of_text;

  logic                accept;
  logic                emit;
  logic                term;
  logic                is_pad;
  logic [BYTE_W-1:0]   byte_next;
  sextet_t             sx;

  // Take a character whenever the output register is free or being emptied
  assign char_in.ready = !out_valid || byte_out.ready;
  assign accept        = char_in.valid && char_in.ready;

  assign sx     = char_to_sextet(char_in.char_code);
  assign is_pad = (char_in.char_code == PAD_CHAR);

  // Slot decode: next state and the byte this character produces
  always_comb begin
    group_slot_next  = group_slot;
    held_sextet_next = held_sextet;
    skip_rest_next   = skip_rest;
    emit             = 1'b0;
    term             = 1'b0;
    byte_next        = '0;
    case (group_slot)
      SLOT_0: begin
        if (char_in.char_code == NUL_CHAR) begin
          // end of text: terminator, group stays at its start
          emit             = 1'b1;
          term             = 1'b1;
          held_sextet_next = '0;
          skip_rest_next   = 1'b0;
        end else begin
          held_sextet_next = sx.sextet;
          group_slot_next  = SLOT_1;
        end
      end
      SLOT_1: begin
        emit             = 1'b1;
        byte_next        = {held_sextet, sx.sextet[5:4]};
        held_sextet_next = sx.sextet;
        group_slot_next  = SLOT_2;
      end
      SLOT_2: begin
        if (is_pad) begin
          skip_rest_next = 1'b1;
        end else begin
          emit             = 1'b1;
          byte_next        = {held_sextet[3:0], sx.sextet[5:2]};
          held_sextet_next = sx.sextet;
        end
        group_slot_next = SLOT_3;
      end
      SLOT_3: begin
        // after padding in slot 2 the last character is dropped
        if (!skip_rest && !is_pad) begin
          emit      = 1'b1;
          byte_next = {held_sextet[1:0], sx.sextet};
        end
        skip_rest_next  = 1'b0;
        group_slot_next = SLOT_0;
      end
      default: begin
        group_slot_next = SLOT_0;
        skip_rest_next  = 1'b0;
      end
    endcase
  end

  // Group state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_slot  <= SLOT_0;
      held_sextet <= '0;
      skip_rest   <= 1'b0;
    end else if (accept) begin
      group_slot  <= group_slot_next;
      held_sextet <= held_sextet_next;
      skip_rest   <= skip_rest_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (byte_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      data_byte   <= byte_next;
      bad_symbol  <= sx.bad && !term;
      end_of_text <= term;
    end
  end

  assign byte_out.valid       = out_valid;
  assign byte_out.data_byte   = data_byte;
  assign byte_out.bad_symbol  = bad_symbol;
  assign byte_out.end_of_text = end_of_text;

endmodule

// File: src/b64sd_checker.sv
`include "base64_stream_decoder_defines.svh"

module b64sd_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [b64sd_pkg::BYTE_W-1:0] out_byte,
  input logic                    out_bad,
  input logic                    out_end
);
  import b64sd_pkg::*;

  // Terminator carries a zero byte and no bad-symbol flag
  `B64SD_ASSERT_NOW(a_term_clean, out_valid && out_end, (out_byte == '0) && !out_bad, "terminator result not clean")

  // A stalled result holds its payload
  `B64SD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_bad) && $stable(out_end), "stalled result changed")

  // Input is never held off while the output register is empty
  `B64SD_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")

  // No result appears without a character transfer behind it
  `B64SD_ASSERT_NEXT(a_no_phantom, !(in_valid && in_ready) && !(out_valid && !out_ready), !out_valid, "result without a character")

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (char_in.valid),
  .in_ready  (char_in.ready),
  .out_valid (byte_out.valid),
  .out_ready (byte_out.ready),
  .out_byte  (byte_out.data_byte),
  .out_bad   (byte_out.bad_symbol),
  .out_end   (byte_out.end_of_text)
);
